// File: rtl/pulse_tachometer_rpm_average_defines.svh
// Assertion macros used by the top-level asserting file.
`ifndef PULSE_TACHOMETER_RPM_AVERAGE_DEFINES_SVH
`define PULSE_TACHOMETER_RPM_AVERAGE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, checked out of reset.
`define PTRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/pta_pkg.sv
package pta_pkg;

  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned DIV_STEPS = ACC_W;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

  localparam logic [FIELD_W-1:0] RPM_SCALE_RESET = 16'd3750;  // 60000 / 16
  localparam logic [COUNT_W-1:0] AVG_COUNT_RESET = 8'd8;
  localparam logic [FIELD_W-1:0] RPM_SAT         = 16'hFFFF;

  typedef enum logic {
    CFG_RPM_SCALE = 1'b0,
    CFG_AVG_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;  // latch the input beat
    logic load;     // load the divider
    logic step;     // one restoring-division step
    logic commit;   // update state / emit result
  } cmd_t;

  typedef struct packed {
    logic emit;      // this window emits an average
    logic out_free;  // output register can take a result
  } sts_t;

endpackage

// File: rtl/pulse_tachometer_rpm_average.sv
// Tachometer speed averager. Each input beat is one finished measurement
// window (pulse_count, window_ms). A sample speed pulse_count * rpm_scale /
// window_ms is formed; the first averaging_count samples are summed, and the
// window after that emits the sum / averaging_count (saturated at 65535)
// while its own sample is dropped, then the sum restarts. A zero-length
// window adds 0 and raises zero_window_seen on the next emitted average.
// Each beat passes through capture, multiply, the shared radix-2 restoring
// divider (40-bit dividend, one quotient bit per cycle) and commit before
// the next beat can be taken. The divider forms the sample speed on
// accumulating windows and the average on emitting ones. An emitting window
// waits in commit only while an earlier result still sits unread in the
// output register. Config (rpm_scale at index 0, averaging_count at index 1)
// is written through cfg_write/cfg_index/cfg_data by the user only while the
// block is idle; the block itself does not enforce this.
`include "pulse_tachometer_rpm_average_defines.svh"

module pulse_tachometer_rpm_average
  import pta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [FIELD_W-1:0] cfg_data,
  // input beats
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FIELD_W-1:0] pulse_count,
  input  logic [FIELD_W-1:0] window_ms,
  // result beats
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] average_rpm,
  output logic               zero_window_seen
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle / multiply / divide / commit
  pta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // config registers, running sum, multiplier, divider, output register
  pta_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pulse_count      (pulse_count),
    .window_ms        (window_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .average_rpm      (average_rpm),
    .zero_window_seen (zero_window_seen),
    .cmd              (cmd),
    .sts              (sts)
  );

  // one beat in flight at a time
  `PTRA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // an emitting commit always presents a result next cycle
  `PTRA_ASSERT_NEXT(a_emit_shows, cmd.commit && sts.emit, out_valid)
  // commit never overwrites an unread result
  `PTRA_ASSERT_NOW(a_no_overwrite, cmd.commit && sts.emit, !out_valid || out_ready)

endmodule

// File: rtl/pta_ctrl.sv
module pta_ctrl
  import pta_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.load    = (state == S_MUL);
  assign cmd.step    = (state == S_DIV);
  assign cmd.commit  = (state == S_FIN) && (!sts.emit || sts.out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL:  state_next = S_DIV;
      S_DIV:  if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = S_FIN;
      S_FIN:  if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        step_cnt <= '0;
      end else if (cmd.step) begin
        step_cnt <= step_cnt + STEP_W'(1);
      end
    end
  end

endmodule

// File: rtl/pta_datapath.sv
module pta_datapath
  import pta_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [FIELD_W-1:0] cfg_data,
  input  logic [FIELD_W-1:0] pulse_count,
  input  logic [FIELD_W-1:0] window_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FIELD_W-1:0] average_rpm,
  output logic               zero_window_seen,
  input  cmd_t               cmd,
  output sts_t               sts
);

  logic [FIELD_W-1:0]   rpm_scale;
  logic [COUNT_W-1:0]   averaging_count;
  logic [COUNT_W-1:0]   sample_counter;
  logic [ACC_W-1:0]     speed_accumulator;
  logic                 zero_window_flag;

  logic [FIELD_W-1:0]   pulse_r, window_r;
  logic                 zero_r, emit_r;

  logic [ACC_W-1:0]     dvd;   // dividend, shifts into quotient
  logic [FIELD_W-1:0]   dvs;
  logic [FIELD_W-1:0]   rem;

  logic [2*FIELD_W-1:0] product;
  logic [COUNT_W-1:0]   avg_div;
  logic [FIELD_W:0]     rem_ext;
  logic                 rem_ge;
  logic [FIELD_W:0]     rem_sub;

  assign product = pulse_r * rpm_scale;
  assign avg_div = (averaging_count == '0) ? COUNT_W'(1) : averaging_count;
  assign rem_ext = {rem, dvd[ACC_W-1]};
  assign rem_ge  = (rem_ext >= {1'b0, dvs});
  assign rem_sub = rem_ext - {1'b0, dvs};

  assign sts.emit     = emit_r;
  assign sts.out_free = !out_valid || out_ready;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_scale       <= RPM_SCALE_RESET;
      averaging_count <= AVG_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RPM_SCALE: rpm_scale       <= cfg_data;
        CFG_AVG_COUNT: averaging_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture and divider
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pulse_r  <= pulse_count;
      window_r <= window_ms;
      zero_r   <= (window_ms == '0);
      emit_r   <= !(sample_counter < averaging_count);
    end
    if (cmd.load) begin
      rem <= '0;
      if (emit_r) begin
        dvd <= speed_accumulator;
        dvs <= FIELD_W'(avg_div);
      end else begin
        dvd <= ACC_W'(product);
        dvs <= window_r;
      end
    end else if (cmd.step) begin
      rem <= rem_ge ? rem_sub[FIELD_W-1:0] : rem_ext[FIELD_W-1:0];
      dvd <= {dvd[ACC_W-2:0], rem_ge};
    end
  end

  // running state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter    <= '0;
      speed_accumulator <= '0;
      zero_window_flag  <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cmd.commit && emit_r) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        if (emit_r) begin
          sample_counter    <= '0;
          speed_accumulator <= '0;
          zero_window_flag  <= 1'b0;
        end else begin
          sample_counter    <= sample_counter + COUNT_W'(1);
          speed_accumulator <= speed_accumulator + (zero_r ? ACC_W'(0) : dvd);
          zero_window_flag  <= zero_window_flag | zero_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && emit_r) begin
      average_rpm      <= (|dvd[ACC_W-1:FIELD_W]) ? RPM_SAT : dvd[FIELD_W-1:0];
      zero_window_seen <= zero_window_flag | zero_r;
    end
  end

endmodule
